### rtl/ipv4_lpm_pkg.sv
// Shared types, constants and helper functions for the IPv4 longest-prefix-match core.
// Used by every module in rtl/; depends on nothing else.

package ipv4_lpm_pkg;

  localparam int NUM_ENTRIES_DEF = 8;
  localparam int IDX_W           = 3;
  localparam int ADDR_W          = 32;
  localparam int PLEN_W          = 6;
  localparam logic [PLEN_W-1:0] PLEN_MAX = 6'd32;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_t;

  // One request as it moves down the chain of table cells.
  typedef struct packed {
    logic                vld;
    action_t             action;
    logic [IDX_W-1:0]    index;
    logic [ADDR_W-1:0]   network;
    logic [PLEN_W-1:0]   prefix_len;
    logic                entry_valid;
    logic [ADDR_W-1:0]   addr;
    logic                hit;
    logic [IDX_W-1:0]    best_idx;
    logic [PLEN_W-1:0]   best_len;
  } item_t;

  typedef struct packed {
    logic                found;
    logic [IDX_W-1:0]    match_index;
    logic [PLEN_W-1:0]   match_prefix_len;
  } result_t;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
    logic [ADDR_W-1:0] ones;
    ones = '1;
    // A shift by 32 or more leaves zero, so a length of 32 gives all ones.
    return ~(ones >> len);
  endfunction

  function automatic logic [PLEN_W-1:0] sat_prefix(input logic [PLEN_W-1:0] len);
    return (len > PLEN_MAX) ? PLEN_MAX : len;
  endfunction

endpackage

### rtl/ipv4_lpm_cell.sv
// One table slot of the longest-prefix-match chain plus its output stage register.
// Depends on ipv4_lpm_pkg.

module ipv4_lpm_cell import ipv4_lpm_pkg::*; #(
  parameter int CELL_ID = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv_i,
  input  item_t item_i,
  output item_t item_o
);

  localparam bit WRITABLE = (CELL_ID < (1 << IDX_W));
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

  logic [ADDR_W-1:0] ent_net_r,    ent_net_nxt;
  logic [PLEN_W-1:0] ent_plen_r,   ent_plen_nxt;
  logic              ent_valid_r,  ent_valid_nxt;
  logic              out_vld_r;
  item_t             out_r,        out_nxt;
  logic              is_write;
  logic              better;

  always_comb begin
    is_write      = item_i.vld && (item_i.action == ACT_WRITE) && WRITABLE &&
                    (item_i.index == MY_IDX);
    ent_net_nxt   = is_write ? item_i.network     : ent_net_r;
    ent_plen_nxt  = is_write ? item_i.prefix_len  : ent_plen_r;
    ent_valid_nxt = is_write ? item_i.entry_valid : ent_valid_r;

    // Slots are visited in ascending order, so only a strictly longer prefix replaces.
    better = item_i.vld && (item_i.action == ACT_LOOKUP) && ent_valid_r &&
             (!item_i.hit || (ent_plen_r > item_i.best_len)) &&
             ((item_i.addr & prefix_mask(ent_plen_r)) == ent_net_r);

    out_nxt = item_i;
    if (better) begin
      out_nxt.hit      = 1'b1;
      out_nxt.best_idx = MY_IDX;
      out_nxt.best_len = ent_plen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_net_r   <= '0;
      ent_plen_r  <= '0;
      ent_valid_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else if (adv_i) begin
      ent_net_r   <= ent_net_nxt;
      ent_plen_r  <= ent_plen_nxt;
      ent_valid_r <= ent_valid_nxt;
      out_vld_r   <= item_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      out_r <= out_nxt;
    end
  end

  always_comb begin
    item_o     = out_r;
    item_o.vld = out_vld_r;
  end

  a_plen_range: assert property (@(posedge clk) disable iff (!rst_n)
    ent_plen_r <= PLEN_MAX)
    else $error("slot holds a prefix longer than 32");

  a_hit_kept: assert property (@(posedge clk) disable iff (!rst_n)
    adv_i && item_i.vld && item_i.hit |=> item_o.hit && (item_o.best_len >= $past(item_i.best_len)))
    else $error("a lookup lost its earlier match");

  a_write_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    adv_i && item_i.vld && (item_i.action == ACT_WRITE) && !item_i.hit |=> !item_o.hit)
    else $error("a write request picked up a match");

endmodule

### rtl/ipv4_lpm_skid.sv
// Two-entry output queue that decouples the cell chain from the result receiver.
// Depends on ipv4_lpm_pkg.

module ipv4_lpm_skid import ipv4_lpm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_i,
  input  result_t data_i,
  output logic    room_o,
  output logic    out_tvalid,
  input  logic    out_tready,
  output result_t data_o
);

  logic [1:0] cnt_r, cnt_nxt;
  result_t    head_r, head_nxt;
  result_t    tail_r, tail_nxt;
  logic       pop;

  always_comb begin
    pop      = out_tvalid && out_tready;
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    case ({push_i, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          head_nxt = data_i;
        end else begin
          tail_nxt = data_i;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        head_nxt = tail_r;
        cnt_nxt  = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          head_nxt = data_i;
        end else begin
          head_nxt = tail_r;
          tail_nxt = data_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign room_o     = (cnt_r != 2'd2);
  assign out_tvalid = (cnt_r != 2'd0);
  assign data_o     = head_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> cnt_r != 2'd2)
    else $error("result pushed into a full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    push_i && !pop |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("queue count did not follow a push");

endmodule

### rtl/ipv4_longest_prefix_match_core.sv
// Top level of the IPv4 longest-prefix-match core: input unpacking, the chain of
// table cells and the output queue. Depends on ipv4_lpm_pkg, ipv4_lpm_cell, ipv4_lpm_skid.
//
// Usage. Each request on the in_ stream is either a table write (in_tuser = 0) or a
// lookup (in_tuser = 1). A write loads one slot with a network, a prefix length
// (lengths above 32 are stored as 32) and a valid mark, and gives no result. A lookup
// gives exactly one result on the out_ stream: a found flag in out_tuser, and the
// winning slot and its prefix length in out_tdata. The longest matching prefix wins,
// the lower slot on a tie; with no match all result fields are zero.
// Each of the NUM_ENTRIES slots lives in its own cell; requests move one cell per
// cycle while the output queue has room, so a write reaches its slot in order with
// the lookups around it. Throughput is one request per cycle unless the queue is full.
// A lookup's result is registered at the output of every cell in turn and is then
// loaded into the output queue.
// Reset (rst_n low, synchronous) clears every slot to invalid and empties the chain
// and the output queue. When the receiver stalls, results collect in a two-entry
// queue; once it is full the whole chain holds and in_tready goes low. in_tready
// depends only on registered state, never combinationally on out_tready.

module ipv4_longest_prefix_match_core import ipv4_lpm_pkg::*; #(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [2:0] entry_index, [34:3] entry_network, [40:35] entry_prefix_len,
  // [41] entry_valid, [73:42] lookup_addr, [79:74] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] action
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] match_index, [8:3] match_prefix_len, [15:9] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] found
  output logic                   out_tuser
);

  item_t   chain [NUM_ENTRIES+1];
  logic    adv;
  logic    push;
  result_t res_in;
  result_t res_out;

  // The chain moves whenever the output queue has a free place.
  assign in_tready = adv;

  always_comb begin
    chain[0].vld         = in_tvalid && adv;
    chain[0].action      = action_t'(in_tuser);
    chain[0].index       = in_tdata[2:0];
    chain[0].network     = in_tdata[34:3];
    chain[0].prefix_len  = sat_prefix(in_tdata[40:35]);
    chain[0].entry_valid = in_tdata[41];
    chain[0].addr        = in_tdata[73:42];
    chain[0].hit         = 1'b0;
    chain[0].best_idx    = '0;
    chain[0].best_len    = '0;
  end

  for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
    ipv4_lpm_cell #(
      .CELL_ID(g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv_i  (adv),
      .item_i (chain[g]),
      .item_o (chain[g+1])
    );
  end

  // Only lookups leave a result; writes retire silently at the end of the chain.
  assign push = adv && chain[NUM_ENTRIES].vld && (chain[NUM_ENTRIES].action == ACT_LOOKUP);

  always_comb begin
    res_in.found            = chain[NUM_ENTRIES].hit;
    res_in.match_index      = chain[NUM_ENTRIES].best_idx;
    res_in.match_prefix_len = chain[NUM_ENTRIES].best_len;
  end

  ipv4_lpm_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .data_i     (res_in),
    .room_o     (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .data_o     (res_out)
  );

  assign out_tuser = res_out.found;
  assign out_tdata = {7'd0, res_out.match_prefix_len, res_out.match_index};

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("a miss carries a nonzero slot or prefix");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[8:3] <= PLEN_MAX)
    else $error("result prefix longer than 32");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("core not empty after reset");

endmodule

### dv/ipv4_longest_prefix_match_core_tb.sv
// Self-checking testbench for ipv4_longest_prefix_match_core: directed table rows, then random
// route-table writes and lookups under random stalls, checked against an in-bench route predictor.
// Depends on rtl/ipv4_lpm_pkg.sv and rtl/ipv4_longest_prefix_match_core.sv.

module ipv4_longest_prefix_match_core_tb;
  import ipv4_lpm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS     = NUM_ENTRIES_DEF;
  localparam int CHAIN_LATENCY = NUM_SLOTS + 1;
  localparam int RANDOM_COUNT  = 450;
  localparam int CALM_TAIL     = 60;

  // One request as the stimulus sees it; typed rows carry their own expected result.
  typedef struct {
    action_t           act;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] net;
    logic [PLEN_W-1:0] plen;
    logic              ent_valid;
    logic [ADDR_W-1:0] addr;
    bit                typed;
    result_t           res;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  // Predictor copy of the route table.
  logic [ADDR_W-1:0] route_net [NUM_SLOTS];
  logic [PLEN_W-1:0] route_len [NUM_SLOTS];
  logic              route_on  [NUM_SLOTS];

  result_t pending_routes [$];
  int      errors = 0;
  bit      idle_on = 1'b1;
  int      stall_left = 0;

  // Directed requests: reset state, extremes, tie-break, saturation, unmasked network,
  // invalid slot, default route and ignored fields.
  stim_row_t directed_rows [23] = '{
    '{ACT_LOOKUP, 3'd0, 32'h0000_0000, 6'd0,  1'b0, 32'h0000_0000, 1'b1, '{1'b0, 3'd0, 6'd0}},
    '{ACT_LOOKUP, 3'd7, 32'hFFFF_FFFF, 6'd63, 1'b1, 32'hFFFF_FFFF, 1'b1, '{1'b0, 3'd0, 6'd0}},
    '{ACT_WRITE,  3'd7, 32'h0000_0000, 6'd0,  1'b1, 32'hFFFF_FFFF, 1'b0, '{1'b0, 3'd0, 6'd0}},
    '{ACT_LOOKUP, 3'd0, 32'h0000_0000, 6'd0,  1'b0, 32'h1234_5678, 1'b1, '{1'b1, 3'd7, 6'd0}},
    '{ACT_WRITE,  3'd0, 32'hFFFF_FFFF, 6'd32, 1'b1, 32'h0000_0000, 1'b0, '{1'b0, 3'd0, 6'd0}},
    '{ACT_LOOKUP, 3'd0, 32'h0000_0000, 6'd0,  1'b0, 32'hFFFF_FFFF, 1'b1, '{1'b1, 3'd0, 6'd32}},
    '{ACT_LOOKUP, 3'd0, 32'h0000_0000, 6'd0,  1'b0, 32'hFFFF_FFFE, 1'b0, '{1'b0, 3'd0, 6'd0}},
    '{ACT_WRITE,  3'd1, 32'hC0A8_0000, 6'd16, 1'b1, 32'h0000_0000, 1'b0, '{1'b0, 3'd0, 6'd0}},
    '{ACT_WRITE,  3'd2, 32'hC0A8_0000, 6'd16, 1'b1, 32'h0000_0000, 1'b0, '{1'b0, 3'd0, 6'd0}},
    '{ACT_LOOKUP, 3'd0, 32'h0000_0000, 6'd0,  1'b0, 32'hC0A8_ABCD, 1'b0, '{1'b0, 3'd0, 6'd0}},
    '{ACT_WRITE,  3'd3, 32'hC0A8_0100, 6'd63, 1'b1, 32'h0000_0000, 1'b0, '{1'b0, 3'd0, 6'd0}},
    '{ACT_LOOKUP, 3'd0, 32'h0000_0000, 6'd0,  1'b0, 32'hC0A8_0100, 1'b0, '{1'b0, 3'd0, 6'd0}},
    '{ACT_LOOKUP, 3'd0, 32'h0000_0000, 6'd0,  1'b0, 32'hC0A8_0101, 1'b0, '{1'b0, 3'd0, 6'd0}},
    '{ACT_WRITE,  3'd4, 32'h0A00_0001, 6'd8,  1'b1, 32'h0000_0000, 1'b0, '{1'b0, 3'd0, 6'd0}},
    '{ACT_LOOKUP, 3'd0, 32'h0000_0000, 6'd0,  1'b0, 32'h0A00_0001, 1'b0, '{1'b0, 3'd0, 6'd0}},
    '{ACT_WRITE,  3'd5, 32'h8000_0000, 6'd1,  1'b0, 32'h0000_0000, 1'b0, '{1'b0, 3'd0, 6'd0}},
    '{ACT_LOOKUP, 3'd0, 32'h0000_0000, 6'd0,  1'b0, 32'h8000_0000, 1'b0, '{1'b0, 3'd0, 6'd0}},
    '{ACT_WRITE,  3'd5, 32'h8000_0000, 6'd33, 1'b1, 32'h0000_0000, 1'b0, '{1'b0, 3'd0, 6'd0}},
    '{ACT_LOOKUP, 3'd0, 32'h0000_0000, 6'd0,  1'b0, 32'h8000_0000, 1'b0, '{1'b0, 3'd0, 6'd0}},
    '{ACT_WRITE,  3'd7, 32'h0000_0000, 6'd0,  1'b0, 32'h0000_0000, 1'b0, '{1'b0, 3'd0, 6'd0}},
    '{ACT_LOOKUP, 3'd0, 32'h0000_0000, 6'd0,  1'b0, 32'h0102_0304, 1'b1, '{1'b0, 3'd0, 6'd0}},
    '{ACT_WRITE,  3'd6, 32'h0000_0000, 6'd0,  1'b1, 32'h0000_0000, 1'b0, '{1'b0, 3'd0, 6'd0}},
    '{ACT_LOOKUP, 3'd0, 32'h0000_0000, 6'd0,  1'b0, 32'h0000_0000, 1'b0, '{1'b0, 3'd0, 6'd0}}
  };

  ipv4_longest_prefix_match_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] route_mask(input logic [PLEN_W-1:0] len);
    if (len == '0) return '0;
    if (len >= 6'd32) return '1;
    return 32'hFFFF_FFFF << (6'd32 - len);
  endfunction

  // Longest valid match wins; a strictly longer prefix is needed to displace a hit,
  // so the lower slot keeps a tie.
  function automatic result_t predict_route(input logic [ADDR_W-1:0] addr);
    result_t best;
    best = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (route_on[s] && (!best.found || route_len[s] > best.match_prefix_len) &&
          (addr & route_mask(route_len[s])) == route_net[s]) begin
        best.found            = 1'b1;
        best.match_index      = s[IDX_W-1:0];
        best.match_prefix_len = route_len[s];
      end
    end
    return best;
  endfunction

  // Mostly well-formed routes and lookups that land inside a stored route, with some
  // unmasked networks, oversized prefixes, invalid slots and random addresses as noise.
  function automatic stim_row_t random_request();
    stim_row_t r;
    int        s;
    logic [ADDR_W-1:0] m;
    r.idx       = IDX_W'($urandom_range(0, NUM_SLOTS - 1));
    r.net       = $urandom;
    r.plen      = ($urandom_range(0, 6) == 0) ? PLEN_W'($urandom_range(33, 63))
                                              : PLEN_W'($urandom_range(0, 32));
    r.ent_valid = ($urandom_range(0, 6) != 0);
    r.addr      = $urandom;
    r.typed     = 1'b0;
    r.res       = '0;
    if ($urandom_range(0, 9) < 3) begin
      r.act = ACT_WRITE;
      if ($urandom_range(0, 9) == 0) begin
        r.net  = '0;
        r.plen = '0;
      end else if ($urandom_range(0, 4) != 0) begin
        r.net = r.net & route_mask(r.plen);
      end
    end else begin
      r.act = ACT_LOOKUP;
      if ($urandom_range(0, 9) < 7) begin
        s = $urandom_range(0, NUM_SLOTS - 1);
        m = route_mask(route_len[s]);
        r.addr = (route_net[s] & m) | (r.addr & ~m);
      end
    end
    return r;
  endfunction

  // Drives one request from a falling edge and holds it until it is accepted, then
  // updates the predicted table or queues the expected result of a lookup.
  task automatic send_request(input stim_row_t r);
    int gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.act;
    in_tdata  <= {6'b0, r.addr, r.ent_valid, r.plen, r.net, r.idx};
    do @(posedge clk); while (!in_tready);
    if (r.act == ACT_WRITE) begin
      route_net[r.idx] = r.net;
      route_len[r.idx] = (r.plen > 6'd32) ? 6'd32 : r.plen;
      route_on[r.idx]  = r.ent_valid;
    end else begin
      pending_routes.push_back(r.typed ? r.res : predict_route(r.addr));
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk);
  endtask

  // Receiver back-pressure in random bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_routes.size() == 0) begin
        $display("%0t: unexpected result found=%0b index=%0d len=%0d", $time,
                 out_tuser, out_tdata[2:0], out_tdata[8:3]);
        errors++;
      end else begin
        want = pending_routes.pop_front();
        if (out_tuser !== want.found) begin
          $display("%0t: found expected %0b got %0b", $time, want.found, out_tuser);
          errors++;
        end
        if (out_tdata[2:0] !== want.match_index) begin
          $display("%0t: match_index expected %0d got %0d", $time,
                   want.match_index, out_tdata[2:0]);
          errors++;
        end
        if (out_tdata[8:3] !== want.match_prefix_len) begin
          $display("%0t: match_prefix_len expected %0d got %0d", $time,
                   want.match_prefix_len, out_tdata[8:3]);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      route_net[s] = '0;
      route_len[s] = '0;
      route_on[s]  = 1'b0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_request(directed_rows[i]);

    for (int n = 0; n < RANDOM_COUNT; n++) begin
      // Halfway through, let every pending lookup result come out before going on.
      if (n == RANDOM_COUNT / 2) wait_drained();
      if (n == RANDOM_COUNT - CALM_TAIL) idle_on = 1'b0;
      send_request(random_request());
    end

    wait_drained();
    repeat (CHAIN_LATENCY + 4) @(posedge clk);
    if (errors == 0) $display("ipv4_longest_prefix_match_core_tb: PASS");
    else $display("ipv4_longest_prefix_match_core_tb: FAIL");
    $finish;
  end

  // Far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("ipv4_longest_prefix_match_core_tb: FAIL");
    $finish;
  end

endmodule
